>>> hw/rtl/lgs_pkg.sv
// Shared definitions for the Life generation stream unit (rule B3/S23).
// Register widths, reset values, register indexes, rule constants and the
// neighbourhood result struct. No dependencies.
package lgs_pkg;

    localparam int GRID_WIDTH_W  = 10;
    localparam int GRID_HEIGHT_W = 9;
    localparam int CFG_DATA_W    = GRID_WIDTH_W;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 10'd512;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 9'd256;

    // smallest legal grid dimension
    localparam int GRID_MIN = 3;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    localparam int OUT_COL_W = 9;
    localparam int OUT_ROW_W = 8;

    typedef struct packed {
        logic       next_alive;
        logic [3:0] live_neighbours;
    } t_eval;

endpackage

>>> hw/rtl/lgs_line_store.sv
// Two one-bit row stores (upper, middle) for the Life generation stream unit.
// Registered read at a prefetch address; write shifts middle into upper.
// No package dependency.
module lgs_line_store #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic                         i_wr_cell,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic                         o_upper,
    output logic                         o_middle
);

    logic r_upper_mem  [MAX_WIDTH];
    logic r_middle_mem [MAX_WIDTH];
    logic r_upper_q;
    logic r_middle_q;

    // The read of i_wr_addr was prefetched one transfer earlier, so r_middle_q
    // holds middle[i_wr_addr] when the write happens.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr]  <= r_middle_q;
            r_middle_mem[i_wr_addr] <= i_wr_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upper_q  <= r_upper_mem[i_rd_addr];
        r_middle_q <= r_middle_mem[i_rd_addr];
    end

    assign o_upper  = r_upper_q;
    assign o_middle = r_middle_q;

endmodule

>>> hw/rtl/lgs_rule_eval.sv
// Neighbour count and B3/S23 next state for one 3x3 window.
// Depends on lgs_pkg (t_eval, rule constants).
module lgs_rule_eval (
    input  logic          [8:0] i_window,
    output lgs_pkg::t_eval      o_eval
);
    import lgs_pkg::*;

    logic [3:0] cnt;

    always_comb begin
        cnt = 4'd0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                cnt = cnt + {3'b000, i_window[k]};
            end
        end
        o_eval.live_neighbours = cnt;
        o_eval.next_alive      = (cnt == BIRTH_COUNT) ||
                                 (i_window[4] && (cnt == SURVIVE_COUNT));
    end

endmodule

>>> hw/rtl/life_generation_stream_unit.sv
// Top level of the Life generation stream unit: raster counters, 3x3 window,
// output register. Depends on lgs_pkg, lgs_line_store, lgs_rule_eval.
//
// Usage:
//   Slave stream carries one generation in raster order: tuser = 0 with
//   tdata[0] the cell state, or tuser = 1 for a drain transfer. After the
//   grid_width*grid_height cells of a frame, grid_width+1 drain transfers
//   flush the remaining results; the last one carries tlast on the master
//   side. Mismatched transfers (drain mid-frame, cell while draining) are
//   taken and dropped.
//   Master stream gives the next state, neighbour count, column and row of
//   each cell in raster order, one row plus one cell behind the input.
//   Throughput is one transfer per cycle while the receiver takes results;
//   the result of an accepted transfer is registered in the output register. The line store
//   read is prefetched for the next column so it never stalls the window.
//   A stalled receiver holds the output register; the slave side accepts in
//   the same cycle the held result is taken.
//   Reset (sync, active low) sets the grid to 512x256 (clamped to the
//   maximums) and restarts the frame; line stores need no clearing. A write
//   to either register also restarts the frame.
module life_generation_stream_unit #(
    parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [0] cell_alive, [7:1] zero
    input  logic                          i_s_tuser,   // [0] req_type
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] next_alive, [4:1] live_neighbours, [13:5] out_col, [21:14] out_row,
    // [23:22] zero
    output logic [23:0]                   o_m_tdata,
    output logic                          o_m_tlast     // frame_last
);
    import lgs_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WXW = (CW > GRID_WIDTH_W) ? CW : GRID_WIDTH_W;
    localparam int HXW = (RW > GRID_HEIGHT_W) ? RW : GRID_HEIGHT_W;

    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;
    logic [CW-1:0]            r_col, n_col;
    logic [RW-1:0]            r_row, n_row;
    logic [8:0]               r_win, n_win;

    logic                     r_out_valid;
    logic                     r_out_alive;
    logic [3:0]               r_out_cnt;
    logic [OUT_COL_W-1:0]     r_out_col;
    logic [OUT_ROW_W-1:0]     r_out_row;
    logic                     r_out_last;

    logic [WXW-1:0] w_ext;
    logic [HXW-1:0] h_ext;
    logic [CW-1:0]  eff_w;
    logic [RW-1:0]  eff_h;

    logic           accept_in, drain, in_cell, draining, valid_item, in_range;
    logic           top_bit, mid_bit, up_rd, mid_rd, emit, last;
    logic [2:0]     colbits;
    logic [8:0]     eval_win;
    logic [OUT_COL_W-1:0] emit_col;
    logic [OUT_ROW_W-1:0] emit_row;
    t_eval          eval;

    // clamp registers to the legal range
    always_comb begin
        w_ext = WXW'(r_grid_width);
        if (w_ext < WXW'(GRID_MIN)) begin
            w_ext = WXW'(GRID_MIN);
        end else if (w_ext > WXW'(MAX_WIDTH)) begin
            w_ext = WXW'(MAX_WIDTH);
        end
        h_ext = HXW'(r_grid_height);
        if (h_ext < HXW'(GRID_MIN)) begin
            h_ext = HXW'(GRID_MIN);
        end else if (h_ext > HXW'(MAX_HEIGHT)) begin
            h_ext = HXW'(MAX_HEIGHT);
        end
        eff_w = CW'(w_ext);
        eff_h = RW'(h_ext);
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept_in  = i_s_tvalid && o_s_tready;
    assign drain      = i_s_tuser;
    assign in_cell    = drain ? 1'b0 : i_s_tdata[0];
    assign draining   = (r_row >= eff_h);
    assign valid_item = accept_in && (drain == draining);
    assign in_range   = (r_col < eff_w);

    lgs_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (valid_item && !draining && in_range),
        .i_wr_addr (r_col[AW-1:0]),
        .i_wr_cell (in_cell),
        .i_rd_addr (n_col[AW-1:0]),
        .o_upper   (up_rd),
        .o_middle  (mid_rd)
    );

    always_comb begin
        top_bit = (r_row >= RW'(2)) ? up_rd  : 1'b0;
        mid_bit = (r_row >= RW'(1)) ? mid_rd : 1'b0;
        colbits = in_range ? {in_cell, mid_bit, top_bit} : 3'b000;

        if (r_col == '0) begin
            // row start: close the previous row with a dead column
            eval_win = {3'b000, r_win[8:3]};
            emit     = (r_row >= RW'(2));
            emit_row = OUT_ROW_W'(r_row - RW'(2));
            emit_col = OUT_COL_W'(eff_w - CW'(1));
            n_win    = {colbits, 6'b000000};
        end else begin
            eval_win = {colbits, r_win[8:3]};
            emit     = (r_row >= RW'(1));
            emit_row = OUT_ROW_W'(r_row - RW'(1));
            emit_col = OUT_COL_W'(r_col - CW'(1));
            n_win    = eval_win;
        end
        last = draining && (r_col == eff_w);

        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (valid_item) begin
            if (draining) begin
                if (r_col >= eff_w) begin
                    n_col = '0;
                    n_row = '0;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end else if (r_col + CW'(1) >= eff_w) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    lgs_rule_eval u_rule_eval (
        .i_window (eval_win),
        .o_eval   (eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_col         <= '0;
            r_row         <= '0;
            r_win         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata;
                    CFG_GRID_HEIGHT: r_grid_height <= GRID_HEIGHT_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                r_win <= '0;
            end else if (valid_item) begin
                r_win <= (draining && r_col >= eff_w) ? 9'd0 : n_win;
            end
            if (valid_item && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (valid_item && emit) begin
            r_out_alive <= eval.next_alive;
            r_out_cnt   <= eval.live_neighbours;
            r_out_col   <= emit_col;
            r_out_row   <= emit_row;
            r_out_last  <= last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_row, r_out_col, r_out_cnt, r_out_alive};
    assign o_m_tlast  = r_out_last;

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_item && emit && last) |=> (r_row == '0 && r_col == '0))
        else $error("frame did not restart after its last result");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= eff_w) && (r_row <= eff_h))
        else $error("raster counters beyond grid size");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_item && emit) |=> o_m_tvalid)
        else $error("emitted result not presented");

endmodule
